@@ hdl/radial_dot_antialias_filter_macros.svh @@
// Assertion macros shared by the filter RTL.
`ifndef RADIAL_DOT_ANTIALIAS_FILTER_MACROS_SVH
`define RADIAL_DOT_ANTIALIAS_FILTER_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define RDAF_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define RDAF_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/rdaf_pkg.sv @@
// Shared constants, types and helpers of the radial dot antialias filter.
`default_nettype none
package rdaf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_RADIUS_DEF = 8;

   // Radius fields are sized for the largest supported radius (16).
   localparam int RAD_BITS    = 5;
   localparam int D2_BITS     = 10;
   localparam int TRIAL_BITS  = 12;
   localparam int TARGET_BITS = 25;

   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_SOLID_RADIUS = 2'd2;
   localparam logic [1:0] REG_FADE_RADIUS  = 2'd3;

   localparam logic [10:0] WIDTH_RST  = 11'd1024;
   localparam logic [15:0] HEIGHT_RST = 16'd1024;
   localparam logic [3:0]  SOLID_RST  = 4'd1;
   localparam logic [3:0]  FADE_RST   = 4'd2;

   localparam logic [7:0] WHITE = 8'hFF;
   localparam logic [7:0] BLACK = 8'h00;

   // Weight broadcast from the generator to every cell.
   typedef struct packed {
      logic                we;
      logic [RAD_BITS-1:0] row_dist;
      logic [RAD_BITS-1:0] col_dist;
      logic [7:0]          weight;
   } wgt_wr_type;

   function automatic logic [7:0] min8(input logic [7:0] x, input logic [7:0] y);
      return (x < y) ? x : y;
   endfunction

   function automatic logic [RAD_BITS:0] abs_diff(input logic [RAD_BITS:0] x,
                                                  input logic [RAD_BITS:0] y);
      return (x >= y) ? (x - y) : (y - x);
   endfunction

endpackage
`default_nettype wire

@@ hdl/rdaf_weight_gen.sv @@
// Builds the offset weight table one entry at a time and broadcasts it to the cells.
`default_nettype none
module rdaf_weight_gen #(
   parameter int MAX_RADIUS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [rdaf_pkg::RAD_BITS-1:0] solid_radius,
   input  wire logic [rdaf_pkg::RAD_BITS-1:0] fade_radius,
   output rdaf_pkg::wgt_wr_type              wgt_wr,
   output logic                              done
);
   import rdaf_pkg::*;

   typedef enum logic [2:0] {G_IDLE, G_INIT, G_TRIAL, G_TEST, G_WRITE} gen_state_type;

   localparam logic [RAD_BITS-1:0] LAST_IDX = RAD_BITS'(MAX_RADIUS);

   gen_state_type           state_ff;
   logic [RAD_BITS-1:0]     a_ff, b_ff;
   logic [2:0]              bit_ff;
   logic [7:0]              cur_ff;
   logic [TRIAL_BITS-1:0]   t_ff;
   logic [TARGET_BITS-1:0]  target_ff;
   wgt_wr_type              wr_ff;
   logic                    done_ff;

   logic [D2_BITS-1:0]      d2_in;
   logic [D2_BITS-1:0]      fr2_in, ff2_in;
   logic [RAD_BITS-1:0]     span_in;
   logic [7:0]              trial_in;

   always_comb begin
      d2_in    = D2_BITS'(32'(a_ff) * 32'(a_ff) + 32'(b_ff) * 32'(b_ff));
      fr2_in   = D2_BITS'(32'(solid_radius) * 32'(solid_radius));
      ff2_in   = D2_BITS'(32'(fade_radius) * 32'(fade_radius));
      span_in  = fade_radius - solid_radius;
      trial_in = cur_ff | (8'd1 << bit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         wr_ff    <= '0;
         done_ff  <= 1'b0;
         a_ff     <= '0;
         b_ff     <= '0;
      end else begin
         wr_ff.we <= 1'b0;
         done_ff  <= 1'b0;
         case (state_ff)
            G_IDLE: begin
               if (start) begin
                  a_ff     <= '0;
                  b_ff     <= '0;
                  state_ff <= G_INIT;
               end
            end
            G_INIT: begin
               target_ff <= TARGET_BITS'(32'd65025 * 32'(d2_in));
               cur_ff    <= BLACK;
               bit_ff    <= 3'd7;
               if (d2_in <= fr2_in) begin
                  state_ff <= G_WRITE;
               end else if (fade_radius <= solid_radius || d2_in > ff2_in) begin
                  cur_ff   <= WHITE;
                  state_ff <= G_WRITE;
               end else begin
                  state_ff <= G_TRIAL;
               end
            end
            G_TRIAL: begin
               t_ff     <= TRIAL_BITS'(32'(trial_in) * 32'(span_in)
                                       + 32'd255 * 32'(solid_radius));
               state_ff <= G_TEST;
            end
            G_TEST: begin
               if (TARGET_BITS'(32'(t_ff) * 32'(t_ff)) <= target_ff) begin
                  cur_ff <= trial_in;
               end
               if (bit_ff == 3'd0) begin
                  state_ff <= G_WRITE;
               end else begin
                  bit_ff   <= bit_ff - 3'd1;
                  state_ff <= G_TRIAL;
               end
            end
            G_WRITE: begin
               wr_ff.we       <= 1'b1;
               wr_ff.row_dist <= a_ff;
               wr_ff.col_dist <= b_ff;
               wr_ff.weight   <= cur_ff;
               state_ff       <= G_INIT;
               if (b_ff == LAST_IDX) begin
                  b_ff <= '0;
                  if (a_ff == LAST_IDX) begin
                     done_ff  <= 1'b1;
                     state_ff <= G_IDLE;
                  end else begin
                     a_ff <= a_ff + 1'b1;
                  end
               end else begin
                  b_ff <= b_ff + 1'b1;
               end
            end
            default: state_ff <= G_IDLE;
         endcase
      end
   end

   assign wgt_wr = wr_ff;
   assign done   = done_ff;
endmodule
`default_nettype wire

@@ hdl/rdaf_cell.sv @@
// One window column: black bits of the column, its weights and its masked minimum.
`default_nettype none
module rdaf_cell #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 8,
   parameter int CELL_IDX   = 0,
   localparam int VW = 2 * MAX_RADIUS + 1,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int TW = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          shift_en,
   input  wire logic [VW-1:0]                 vec_in,
   input  wire logic [CW-1:0]                 col_in,
   output logic      [VW-1:0]                 vec_out,
   output logic      [CW-1:0]                 col_out,
   input  wire rdaf_pkg::wgt_wr_type          wgt_wr,
   input  wire logic [rdaf_pkg::RAD_BITS-1:0] radius,
   input  wire logic                          eval_en,
   input  wire logic [VW-1:0]                 row_mask,
   input  wire logic [TW-1:0]                 col_target,
   output logic      [7:0]                    min_out
);
   import rdaf_pkg::*;

   localparam int LV = $clog2(VW);
   localparam int NP = 1 << LV;

   logic [VW-1:0]   vec_ff;
   logic [CW-1:0]   col_ff;
   logic [7:0]      w_ff [VW];
   logic [7:0]      min_ff;

   logic [RAD_BITS:0] col_dist;
   logic              col_ok;
   logic [7:0]        tree [LV+1][NP];

   always_comb begin
      col_dist = abs_diff((RAD_BITS+1)'(CELL_IDX), {1'b0, radius});
      col_ok   = (TW'(col_ff) + TW'(CELL_IDX) == col_target)
               && ((RAD_BITS+1)'(CELL_IDX) <= {radius, 1'b0});
   end

   always_comb begin
      for (int i = 0; i < VW; i++) begin
         tree[0][i] = (vec_ff[i] && row_mask[i] && col_ok) ? w_ff[i] : WHITE;
      end
      for (int i = VW; i < NP; i++) begin
         tree[0][i] = WHITE;
      end
      for (int lv = 0; lv < LV; lv++) begin
         for (int i = 0; i < NP / 2; i++) begin
            tree[lv+1][i] = min8(tree[lv][2*i], tree[lv][2*i+1]);
         end
         for (int i = NP / 2; i < NP; i++) begin
            tree[lv+1][i] = WHITE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         vec_ff <= vec_in;
         col_ff <= col_in;
      end
      if (eval_en) begin
         min_ff <= tree[LV][0];
      end
      if (wgt_wr.we && {1'b0, wgt_wr.col_dist} == col_dist) begin
         for (int k = 0; k < VW; k++) begin
            if (abs_diff((RAD_BITS+1)'(k), {1'b0, radius}) == {1'b0, wgt_wr.row_dist}) begin
               w_ff[k] <= wgt_wr.weight;
            end
         end
      end
   end

   assign vec_out = vec_ff;
   assign col_out = col_ff;
   assign min_out = min_ff;
endmodule
`default_nettype wire

@@ hdl/radial_dot_antialias_filter.sv @@
// Top level of the radial dot antialias filter: control, line memory and cell row.
`default_nettype none
`include "radial_dot_antialias_filter_macros.svh"
// Streams a raster of black (0) / white (255) pixels and returns, for every
// position, the minimum radial weight over nearby black pixels: 0 inside the
// solid radius, a ramp out to the fade radius, white beyond. The window is a
// row of 2*MAX_RADIUS+1 column cells fed from a line memory of 2*MAX_RADIUS
// bits per column (one port written, one read per cycle). While a frame runs
// one request is taken every clock unless the output stalls; a result passes
// the pipeline stages and the output register after the request that completes
// its window, and results come max(R,F) rows plus max(R,F) pixels behind the
// input. Drain requests (cmd=1) push the tail out. The first pixel request of
// a frame is held until the pipeline is empty, then the registers are latched
// and the weight table is rebuilt, (MAX_RADIUS+1)^2 entries one at a time,
// before that request is taken. An output stall stops the whole pipeline.
// Registers sit at byte addresses 0 (width), 4 (height), 8 (solid radius), 12
// (fade radius) and take effect at the next frame start. Levels other than 0
// and 255 count as black and set a sticky error bit that only reset clears.
module radial_dot_antialias_filter
   import rdaf_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_pixel_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_pixel_out,
   output logic             rsp_frame_last,
   output logic             rsp_error_seen,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int VW  = 2 * MAX_RADIUS + 1;
   localparam int MW  = 2 * MAX_RADIUS;
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int FWW = $clog2(MAX_WIDTH + 1);
   localparam int TW  = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 1);
   localparam int LGW = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
   localparam int LV  = $clog2(VW);
   localparam int NP  = 1 << LV;

   typedef enum logic [1:0] {ST_IDLE, ST_BUILD, ST_RUN} state_type;

   // configuration registers
   logic [10:0] cfg_width_ff;
   logic [15:0] cfg_height_ff;
   logic [3:0]  cfg_solid_ff, cfg_fade_ff;

   // frame values latched at frame start
   state_type           state_ff;
   logic [FWW-1:0]      fw_ff;
   logic [15:0]         fh_ff;
   logic [RAD_BITS-1:0] fr_ff, ff_ff, fl_ff;
   logic [LGW-1:0]      lag_ff;
   logic                gen_start_ff;

   // input and output raster counters
   logic [CW-1:0]  c_ff, pc_ff;
   logic [16:0]    r_ff;
   logic [15:0]    pr_ff;
   logic [LGW-1:0] qc_ff;
   logic           err_ff;

   // pipeline stages
   logic           s1_valid_ff, s1_res_ff, s1_last_ff, s1_err_ff, s1_bit_ff, s1_byp_ff;
   logic [15:0]    s1_pr_ff;
   logic [CW-1:0]  s1_pc_ff, s1_col_ff;
   logic [MW-1:0]  s1_byp_data_ff, mem_rd_ff;
   logic           s2_valid_ff, s2_res_ff, s2_last_ff, s2_err_ff;
   logic [VW-1:0]  s2_row_mask_ff;
   logic [TW-1:0]  s2_col_target_ff;
   logic           s3_valid_ff, s3_res_ff, s3_last_ff, s3_err_ff;
   logic           rsp_valid_ff, rsp_last_ff, rsp_err_ff;
   logic [7:0]     rsp_pixel_ff;

   logic [MW-1:0]  line_mem [MAX_WIDTH];

   // combinational
   logic                en, pipe_empty, accept, in_frame, proc, new_bit, err_in;
   logic                res, last, col_wrap;
   logic [VW-1:0]       vec_new, row_mask_in;
   logic [MW-1:0]       old_word;
   logic [17:0]         row_ref;
   logic                shift_en;
   logic [FWW-1:0]      fw_new;
   logic [RAD_BITS-1:0] fr_new, ff_new;
   wgt_wr_type          wgt_wr;
   logic                wgt_done;
   logic [VW-1:0]       cell_vec [VW];
   logic [CW-1:0]       cell_col [VW];
   logic [7:0]          cell_min [VW];
   logic [7:0]          tree [LV+1][NP];

   // ---------------- configuration port ----------------
   assign pready = 1'b1;

   always_comb begin
      case (paddr[3:2])
         REG_IMAGE_WIDTH:  prdata = 32'(cfg_width_ff);
         REG_IMAGE_HEIGHT: prdata = 32'(cfg_height_ff);
         REG_SOLID_RADIUS: prdata = 32'(cfg_solid_ff);
         REG_FADE_RADIUS:  prdata = 32'(cfg_fade_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RST;
         cfg_height_ff <= HEIGHT_RST;
         cfg_solid_ff  <= SOLID_RST;
         cfg_fade_ff   <= FADE_RST;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_IMAGE_WIDTH:  cfg_width_ff  <= pwdata[10:0];
            REG_IMAGE_HEIGHT: cfg_height_ff <= pwdata[15:0];
            REG_SOLID_RADIUS: cfg_solid_ff  <= pwdata[3:0];
            REG_FADE_RADIUS:  cfg_fade_ff   <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // clamped register values for the next frame
   always_comb begin
      if (cfg_width_ff == 11'd0) begin
         fw_new = FWW'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         fw_new = FWW'(MAX_WIDTH);
      end else begin
         fw_new = FWW'(cfg_width_ff);
      end
      fr_new = (32'(cfg_solid_ff) > 32'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS)
                                                     : RAD_BITS'(cfg_solid_ff);
      ff_new = (32'(cfg_fade_ff) > 32'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS)
                                                    : RAD_BITS'(cfg_fade_ff);
   end

   // ---------------- request side ----------------
   // whole pipeline moves when the output register is free or being emptied
   assign en         = !rsp_valid_ff || rsp_ready;
   assign pipe_empty = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE:  req_ready = en && req_cmd;   // drains with no frame are dropped
         ST_RUN:   req_ready = en;
         default:  req_ready = 1'b0;
      endcase
   end

   assign accept   = req_valid && req_ready;
   assign in_frame = r_ff < {1'b0, fh_ff};
   // a drain before the last frame pixel does nothing
   assign proc     = accept && (state_ff == ST_RUN) && !(in_frame && req_cmd);
   assign new_bit  = in_frame && (req_pixel_in != WHITE);
   assign err_in   = err_ff || (in_frame && req_pixel_in != WHITE && req_pixel_in != BLACK);
   assign res      = (qc_ff == lag_ff);
   assign col_wrap = (FWW'(c_ff) + 1'b1 == fw_ff);
   assign last     = (pr_ff + 16'd1 == fh_ff) && (FWW'(pc_ff) + 1'b1 == fw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_start_ff <= 1'b0;
         err_ff       <= 1'b0;
         fw_ff        <= FWW'(1);
         fh_ff        <= 16'd1;
         fr_ff        <= '0;
         ff_ff        <= '0;
         fl_ff        <= '0;
         lag_ff       <= '0;
         c_ff         <= '0;
         r_ff         <= '0;
         pc_ff        <= '0;
         pr_ff        <= '0;
         qc_ff        <= '0;
      end else begin
         gen_start_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_cmd && pipe_empty) begin
                  fw_ff        <= fw_new;
                  fh_ff        <= (cfg_height_ff == 16'd0) ? 16'd1 : cfg_height_ff;
                  fr_ff        <= fr_new;
                  ff_ff        <= ff_new;
                  fl_ff        <= (fr_new > ff_new) ? fr_new : ff_new;
                  c_ff         <= '0;
                  r_ff         <= '0;
                  pc_ff        <= '0;
                  pr_ff        <= '0;
                  qc_ff        <= '0;
                  gen_start_ff <= 1'b1;
                  state_ff     <= ST_BUILD;
               end
            end
            ST_BUILD: begin
               lag_ff <= LGW'(32'(fl_ff) * 32'(fw_ff) + 32'(fl_ff));
               if (wgt_done) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (proc) begin
                  err_ff <= err_in;
                  if (col_wrap) begin
                     c_ff <= '0;
                     r_ff <= r_ff + 17'd1;
                  end else begin
                     c_ff <= c_ff + 1'b1;
                  end
                  if (!res) begin
                     qc_ff <= qc_ff + 1'b1;
                  end else if (last) begin
                     state_ff <= ST_IDLE;
                  end else if (FWW'(pc_ff) + 1'b1 == fw_ff) begin
                     pc_ff <= '0;
                     pr_ff <= pr_ff + 16'd1;
                  end else begin
                     pc_ff <= pc_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ---------------- line memory ----------------
   assign old_word = s1_byp_ff ? s1_byp_data_ff : mem_rd_ff;
   assign vec_new  = {old_word, s1_bit_ff};   // bit k holds row (current - k)
   assign shift_en = en && s1_valid_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         line_mem[s1_col_ff] <= vec_new[MW-1:0];
      end
      if (proc) begin
         mem_rd_ff <= line_mem[c_ff];
      end
   end

   // ---------------- pipeline ----------------
   // rows of the window that lie inside the frame and inside 2L
   always_comb begin
      row_ref = 18'(s1_pr_ff) + 18'(fl_ff);
      for (int k = 0; k < VW; k++) begin
         row_mask_in[k] = (18'(k) <= (18'(fl_ff) << 1)) && (row_ref >= 18'(k))
                        && (row_ref < 18'(fh_ff) + 18'(k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= proc;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff && s3_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: request registered, memory word on its way
         s1_res_ff      <= res;
         s1_last_ff     <= res && last;
         s1_err_ff      <= err_in;
         s1_bit_ff      <= new_bit;
         s1_pr_ff       <= pr_ff;
         s1_pc_ff       <= pc_ff;
         s1_col_ff      <= c_ff;
         // same column written this edge (one-pixel rows): forward it
         s1_byp_ff      <= shift_en && (s1_col_ff == c_ff);
         s1_byp_data_ff <= vec_new[MW-1:0];
         // stage 2: column enters the cell row
         s2_res_ff        <= s1_res_ff;
         s2_last_ff       <= s1_last_ff;
         s2_err_ff        <= s1_err_ff;
         s2_row_mask_ff   <= row_mask_in;
         s2_col_target_ff <= TW'(s1_pc_ff) + TW'(fl_ff);
         // stage 3: per-cell minima ready
         s3_res_ff  <= s2_res_ff;
         s3_last_ff <= s2_last_ff;
         s3_err_ff  <= s2_err_ff;
         // output register
         rsp_pixel_ff <= tree[LV][0];
         rsp_last_ff  <= s3_last_ff;
         rsp_err_ff   <= s3_err_ff;
      end
   end

   // ---------------- weight generator and cell row ----------------
   rdaf_weight_gen #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_weight_gen (
      .clock        (clock),
      .reset        (reset),
      .start        (gen_start_ff),
      .solid_radius (fr_ff),
      .fade_radius  (ff_ff),
      .wgt_wr       (wgt_wr),
      .done         (wgt_done)
   );

   for (genvar j = 0; j < VW; j++) begin : g_cell
      rdaf_cell #(
         .MAX_WIDTH  (MAX_WIDTH),
         .MAX_RADIUS (MAX_RADIUS),
         .CELL_IDX   (j)
      ) u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .vec_in     ((j == 0) ? vec_new : cell_vec[(j == 0) ? 0 : j - 1]),
         .col_in     ((j == 0) ? s1_col_ff : cell_col[(j == 0) ? 0 : j - 1]),
         .vec_out    (cell_vec[j]),
         .col_out    (cell_col[j]),
         .wgt_wr     (wgt_wr),
         .radius     (fl_ff),
         .eval_en    (en),
         .row_mask   (s2_row_mask_ff),
         .col_target (s2_col_target_ff),
         .min_out    (cell_min[j])
      );
   end

   // minimum across the cell row
   always_comb begin
      for (int i = 0; i < VW; i++) begin
         tree[0][i] = cell_min[i];
      end
      for (int i = VW; i < NP; i++) begin
         tree[0][i] = WHITE;
      end
      for (int lv = 0; lv < LV; lv++) begin
         for (int i = 0; i < NP / 2; i++) begin
            tree[lv+1][i] = min8(tree[lv][2*i], tree[lv][2*i+1]);
         end
         for (int i = NP / 2; i < NP; i++) begin
            tree[lv+1][i] = WHITE;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;
   assign rsp_error_seen = rsp_err_ff;

   // ---------------- checks ----------------
   `RDAF_ASSERT_IMPL(a_build_quiet, state_ff == ST_BUILD, pipe_empty && !req_ready, "request taken or pipeline busy during table build")
   `RDAF_ASSERT_NEXT(a_err_sticky, err_ff, err_ff, "error flag cleared without reset")
   `RDAF_ASSERT_IMPL(a_done_in_build, wgt_done, state_ff == ST_BUILD, "table build finished outside build")
endmodule
`default_nettype wire
